// ===== rtl/isrt_pkg.sv =====
// isrt_pkg: shared types for the insertion sorter chain.
// Used by isrt_cell, insertion_sorter and tb_top; no dependencies.
package isrt_pkg;

	localparam int DataW = 32;

	typedef logic signed [DataW-1:0] data_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;   // insert the broadcast value
		logic pop;   // shift the chain one place toward cell 0
	} cell_cmd_t;

	// What a cell shows its neighbors
	typedef struct packed {
		data_t val;
		logic  valid;
		logic  gt;    // broadcast value sorts before this cell's entry (or cell empty)
	} nbr_t;

endpackage

// ===== rtl/isrt_cell.sv =====
// isrt_cell: one entry of the systolic insertion chain.
// Compares the broadcast value, takes its left neighbor on insert, its right on pop.
// Depends on isrt_pkg.
module isrt_cell
	import isrt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  data_t     v,
	input  nbr_t      left,
	input  nbr_t      right,
	output nbr_t      self
);

	data_t val_q;
	logic  valid_q;
	logic  gt;

	// Empty cells always count as greater so the new value lands at the tail
	assign gt = !valid_q || (v < val_q);

	// Valid bit: cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right.valid;
		end else if (cmd.ins && gt) begin
			valid_q <= valid_q | left.valid;
		end
	end

	// Payload: insert takes left neighbor or the new value, pop takes right neighbor
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			val_q <= right.val;
		end else if (cmd.ins && gt) begin
			val_q <= left.gt ? left.val : v;
		end
	end

	assign self.val   = val_q;
	assign self.valid = valid_q;
	assign self.gt    = gt;

endmodule

// ===== rtl/insertion_sorter.sv =====
// insertion_sorter: stable streaming sorter, one systolic chain of DEPTH cells.
// Fill: one value per cycle, inserted into every cell's compare at once.
// Once the beat marked last is accepted, the drain flag is set, then out_valid rises
// and results drain from cell 0 at one per cycle unless the output stalls; the input
// stalls meanwhile.
// Reset clears all cell valid bits, the drain and drop flags and the output valid.
module insertion_sorter
	import isrt_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  data_t value,
	input  logic  last,
	input  logic  in_valid,
	output logic  in_stall,
	output data_t sorted_value,
	output logic  end_of_set,
	output logic  overflowed,
	output logic  out_valid,
	input  logic  out_stall
);

	nbr_t             cell_o [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	cell_cmd_t        cmd;
	logic             in_acc;
	logic             full;
	logic             pop;
	logic             draining_q;
	logic             dropped_q;
	logic             out_valid_q;
	data_t            sorted_value_q;
	logic             end_of_set_q;
	logic             overflowed_q;

	// Chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		nbr_t left_n;
		nbr_t right_n;
		if (i == 0) begin : g_head
			assign left_n = '{val: value, valid: 1'b1, gt: 1'b0};
		end else begin : g_mid
			assign left_n = cell_o[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_n = '{val: '0, valid: 1'b0, gt: 1'b1};
		end else begin : g_body
			assign right_n = cell_o[i+1];
		end
		isrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.v      (value),
			.left   (left_n),
			.right  (right_n),
			.self   (cell_o[i])
		);
		assign cell_valid[i] = cell_o[i].valid;
	end

	// Control decode
	assign in_stall = draining_q;
	assign in_acc   = in_valid && !draining_q;
	assign full     = cell_valid[DEPTH-1];
	assign pop      = draining_q && (!out_valid_q || !out_stall);
	assign cmd.ins  = in_acc && !full;
	assign cmd.pop  = pop;

	// Set control: fill, drop tracking, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (pop && !cell_valid[1]) begin
			draining_q <= 1'b0;
			dropped_q  <= 1'b0;
		end else if (in_acc) begin
			draining_q <= last;
			if (full) begin
				dropped_q <= 1'b1;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			sorted_value_q <= cell_o[0].val;
			end_of_set_q   <= !cell_valid[1];
			overflowed_q   <= dropped_q;
		end
	end

	assign sorted_value = sorted_value_q;
	assign end_of_set   = end_of_set_q;
	assign overflowed   = overflowed_q;
	assign out_valid    = out_valid_q;

	// Occupied cells always form a run starting at cell 0
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + DEPTH'(1))) == '0)
		else $error("cell valid bits not contiguous");

	// A drain always has an entry at the head
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> cell_valid[0])
		else $error("draining with empty chain");

	// Popping the final entry ends the set and clears the drop flag
	a_set_end: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !cell_valid[1]) |=> (!draining_q && !dropped_q && cell_valid == '0))
		else $error("set did not close after final result");

	// An accept on a full chain leaves it full and records the drop
	a_no_ins_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> (cell_valid[DEPTH-1] && dropped_q))
		else $error("drop not recorded on full chain");

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for insertion_sorter; a clocked driver and monitor
// share a running sort predictor. Depends on isrt_pkg and the insertion_sorter RTL.
module tb_top;
	import isrt_pkg::*;

	localparam int SORT_DEPTH  = 32;
	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN_GUARD = 2 * SORT_DEPTH + 16;
	localparam int RAND_BEATS  = 88;
	localparam int CALM_BEATS  = 20;

	typedef struct packed {
		data_t value;
		logic  last;
	} sort_beat_t;

	typedef struct packed {
		data_t value;
		logic  eos;
		logic  ovf;
	} sorted_out_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	data_t value = '0;
	logic  last = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	data_t sorted_value;
	logic  end_of_set;
	logic  overflowed;
	logic  out_valid;
	logic  out_stall = 1'b0;

	sort_beat_t  beats_to_send[$];
	sorted_out_t sorted_expect[$];

	// running copy of the set being collected
	data_t set_vals[SORT_DEPTH];
	int    set_fill = 0;
	logic  set_dropped = 1'b0;

	int    errors = 0;
	int    idle_cycles = 0;
	int    send_gap = 0;
	int    stall_left = 0;
	int    hold_left = 0;
	logic  hold_go = 1'b0;
	logic  hold_done = 1'b0;
	logic  tail_open = 1'b0;
	sort_beat_t  next_beat;
	sorted_out_t want;

	insertion_sorter #(.DEPTH(SORT_DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.last         (last),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set),
		.overflowed   (overflowed),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stable insert of one accepted beat; a last beat flushes the whole set
	task automatic sort_insert(input data_t v, input logic lst);
		int pos;
		sorted_out_t r;
		if (set_fill >= SORT_DEPTH) begin
			set_dropped = 1'b1;
		end else begin
			pos = set_fill;
			// equal values stay behind older ones
			while (pos > 0 && v < set_vals[pos-1]) begin
				set_vals[pos] = set_vals[pos-1];
				pos--;
			end
			set_vals[pos] = v;
			set_fill++;
		end
		if (lst) begin
			for (int k = 0; k < set_fill; k++) begin
				r.value = set_vals[k];
				r.eos   = (k == set_fill - 1);
				r.ovf   = set_dropped;
				sorted_expect.push_back(r);
			end
			set_fill    = 0;
			set_dropped = 1'b0;
		end
	endtask

	task automatic push_beat(input data_t v, input logic lst);
		sort_beat_t b;
		b.value = v;
		b.last  = lst;
		beats_to_send.push_back(b);
	endtask

	// Mix of full-range, clustered (duplicates) and extreme values
	function automatic data_t pick_value();
		data_t v;
		case ($urandom_range(0, 5))
			0: v = data_t'($urandom_range(0, 7)) - 4;
			1: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = -1;
					default: v = 0;
				endcase
			end
			default: v = data_t'($urandom);
		endcase
		return v;
	endfunction

	task automatic push_set(input int n);
		for (int i = 0; i < n; i++) begin
			push_beat(pick_value(), i == n - 1);
		end
	endtask

	// Sender: drives beats from the pending queue, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
			last     <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				sort_insert(value, last);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!(tail_open && beats_to_send.size() < CALM_BEATS) &&
						$urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(1, 18) - 1;
					in_valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					next_beat = beats_to_send.pop_front();
					value    <= next_beat.value;
					last     <= next_beat.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat, applies random and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sorted_expect.size() == 0) begin
					$error("unexpected result beat: sorted_value %0d", sorted_value);
					errors++;
				end else begin
					want = sorted_expect.pop_front();
					if (sorted_value !== want.value) begin
						$error("sorted_value: expected %0d, got %0d", want.value, sorted_value);
						errors++;
					end
					if (end_of_set !== want.eos) begin
						$error("end_of_set: expected %0b, got %0b", want.eos, end_of_set);
						errors++;
					end
					if (overflowed !== want.ovf) begin
						$error("overflowed: expected %0b, got %0b", want.ovf, overflowed);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_go && !hold_done) begin
				hold_left <= LONG_HOLD - 1;
				hold_done <= 1'b1;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (!(tail_open && beats_to_send.size() < CALM_BEATS) &&
					$urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 18) - 1;
				out_stall  <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any accepted beat ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stimulus plan and end of run
	initial begin
		int queued;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-value set
		push_beat(32'sh8000_0000, 1'b1);
		// extremes in mixed order
		push_beat(32'sh7fff_ffff, 1'b0);
		push_beat(32'sh8000_0000, 1'b0);
		push_beat(-1, 1'b0);
		push_beat(0, 1'b0);
		push_beat(1, 1'b1);
		// duplicates
		push_beat(7, 1'b0);
		push_beat(7, 1'b0);
		push_beat(-3, 1'b0);
		push_beat(7, 1'b1);
		// descending run: every insert shifts the whole store
		for (int i = 0; i < 8; i++) begin
			push_beat(100 - 10 * i, i == 7);
		end
		// ascending run: no shifts
		for (int i = 0; i < 4; i++) begin
			push_beat(-50 + i, i == 3);
		end

		// let everything drain before the random part
		do @(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || sorted_expect.size() != 0);

		// long receiver hold while an overflowing set and a full set arrive
		hold_go = 1'b1;
		push_set(SORT_DEPTH + 1);
		push_set(SORT_DEPTH);
		queued = 2 * SORT_DEPTH + 1;
		while (queued < RAND_BEATS) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			push_set(n);
			queued += n;
		end
		tail_open = 1'b1;

		do @(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || sorted_expect.size() != 0);
		repeat (DRAIN_GUARD) @(negedge clk);

		if (errors == 0 && sorted_expect.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/isrt_pkg.sv
rtl/isrt_cell.sv
rtl/insertion_sorter.sv
tb/sv/tb_top.sv
